@@ rtl/mlbd_pkg.sv @@
// Shared types and constants for the MIDI learn binding dispatcher.
`default_nettype none

package mlbd_pkg;

    // Default sizing
    localparam int DEF_NUM_ACTIONS      = 2;
    localparam int DEF_SLOTS_PER_ACTION = 4;
    localparam int DEF_RING_DEPTH       = 16;

    // Channel message status range: [CHANNEL_LOW, CHANNEL_END)
    localparam logic [7:0] CHANNEL_LOW = 8'h80;
    localparam logic [7:0] CHANNEL_END = 8'hF0;

    typedef enum logic [1:0] {
        OP_MIDI  = 2'd0,
        OP_LEARN = 2'd1,
        OP_CLEAR = 2'd2,
        OP_POP   = 2'd3
    } t_op;

    // One binding as seen on the table read port
    typedef struct packed {
        logic       valid;
        logic [7:0] status;
        logic [7:0] data;
    } t_binding;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_tbl_ctl;

    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

    typedef struct packed {
        logic empty;
    } t_ring_sts;

endpackage

`default_nettype wire

@@ rtl/mlbd_table.sv @@
// Binding table: status/data memory with a flip-flop valid bit per entry.
`default_nettype none

module mlbd_table
    import mlbd_pkg::*;
#(
    parameter int TBL_DEPTH = DEF_NUM_ACTIONS * DEF_SLOTS_PER_ACTION,
    localparam int TBL_AW   = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_tbl_ctl          i_ctl,
    input  wire logic [TBL_AW-1:0] i_addr,
    input  wire logic [7:0]        i_wr_status,
    input  wire logic [7:0]        i_wr_data,
    output t_binding               o_rd
);

    logic [15:0]          r_mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] r_vld;
    logic [15:0]          r_rd_word;
    logic                 r_rd_vld;

    // valid bits: cleared at reset, so a never-learned entry reads invalid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.wr) begin
            r_vld[i_addr] <= 1'b1;
        end else if (i_ctl.clr) begin
            r_vld[i_addr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= {i_wr_status, i_wr_data};
        end
        if (i_ctl.rd) begin
            r_rd_word <= r_mem[i_addr];
            r_rd_vld  <= r_vld[i_addr];
        end
    end

    assign o_rd = '{valid: r_rd_vld, status: r_rd_word[15:8], data: r_rd_word[7:0]};

endmodule

`default_nettype wire

@@ rtl/mlbd_ring.sv @@
// Action ring: circular queue memory with head/tail pointers, drop-oldest on full.
`default_nettype none

module mlbd_ring
    import mlbd_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int ACT_W      = 1,
    localparam int RING_AW   = $clog2(RING_DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_ring_ctl        i_ctl,
    input  wire logic [ACT_W-1:0] i_push_action,
    output logic [ACT_W-1:0]      o_pop_action,
    output t_ring_sts             o_sts
);

    logic [ACT_W-1:0]   r_mem [RING_DEPTH];
    logic [RING_AW-1:0] r_head;
    logic [RING_AW-1:0] r_tail;
    logic [ACT_W-1:0]   r_pop_data;
    logic [RING_AW-1:0] head_nxt;
    logic [RING_AW-1:0] tail_nxt;

    function automatic logic [RING_AW-1:0] f_next(input logic [RING_AW-1:0] p);
        return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + RING_AW'(1);
    endfunction

    assign head_nxt = f_next(r_head);
    assign tail_nxt = f_next(r_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (i_ctl.push) begin
            r_head <= head_nxt;
            // full: drop the oldest
            if (head_nxt == r_tail) begin
                r_tail <= tail_nxt;
            end
        end else if (i_ctl.pop) begin
            r_tail <= tail_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_head] <= i_push_action;
        end
        if (i_ctl.pop) begin
            r_pop_data <= r_mem[r_tail];
        end
    end

    assign o_pop_action = r_pop_data;
    assign o_sts.empty  = (r_head == r_tail);

endmodule

`default_nettype wire

@@ rtl/midi_learn_binding_dispatcher_core.sv @@
// Top level of the MIDI learn binding dispatcher: op sequencer and result register.
`default_nettype none

// MIDI learn and dispatch engine. Items carry one op: a MIDI message, arm/disarm
// learn, clear a binding slot, or pop one queued action; each item gives exactly
// one result item. Only channel messages (status 0x80..0xEF) do anything. With
// learn armed, a message is written into the armed slot and learn disarms;
// otherwise the binding table is scanned action-major and the first matching
// action is pushed into the action ring (drop-oldest when full, holding
// RING_DEPTH-1 entries). Items are processed one at a time. A message that
// scans the table keeps the core busy until the next accept; in the worst
// case that covers one table read per cycle through the single read port,
// then the compare of the last entry, then the hand-over to the result
// register. A hit ends the scan early. Learn, clear, non-channel messages
// and a pop of an empty ring go straight to the done state; a pop of a
// non-empty ring first passes through the pop state for the ring memory read.
// While the result register is full and stalled, the next result waits in
// the done state and the input stays stalled. The result register lets the
// next item be accepted while the previous result waits downstream. The
// table valid bits clear at reset, so no clearing pass is needed.
module midi_learn_binding_dispatcher_core
    import mlbd_pkg::*;
#(
    parameter int NUM_ACTIONS      = DEF_NUM_ACTIONS,
    parameter int SLOTS_PER_ACTION = DEF_SLOTS_PER_ACTION,
    parameter int RING_DEPTH       = DEF_RING_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input item channel
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_op,
    input  wire logic [7:0]        i_status_byte,
    input  wire logic [7:0]        i_first_data,
    input  wire logic signed [3:0] i_action_index,
    input  wire logic signed [3:0] i_slot_index,
    // result item channel
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_consumed,
    output logic                   o_learned,
    output logic                   o_popped_valid,
    output logic [2:0]             o_popped_action,
    output logic                   o_learn_armed
);

    localparam int TBL_DEPTH = NUM_ACTIONS * SLOTS_PER_ACTION;
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int ACT_W     = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
    localparam int SLOT_W    = (SLOTS_PER_ACTION > 1) ? $clog2(SLOTS_PER_ACTION) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_DONE
    } t_state;

    t_state              r_state;
    logic                r_armed;
    logic [TBL_AW-1:0]   r_learn_addr;
    logic [7:0]          r_status;
    logic [7:0]          r_data;

    // scan: issue side and compare side (registered behind the issue side)
    logic [ACT_W-1:0]    r_scan_act;
    logic [SLOT_W-1:0]   r_scan_slot;
    logic [TBL_AW-1:0]   r_scan_addr;
    logic                r_issue_done;
    logic                r_cmp_vld;
    logic                r_cmp_last;
    logic [ACT_W-1:0]    r_cmp_act;

    // pending result and output register
    logic                r_res_consumed;
    logic                r_res_learned;
    logic                r_res_pvalid;
    logic [2:0]          r_res_paction;
    logic                r_out_valid;
    logic                r_out_consumed;
    logic                r_out_learned;
    logic                r_out_pvalid;
    logic [2:0]          r_out_paction;
    logic                r_out_armed;

    logic                accept;
    t_op                 op;
    logic                is_chan;
    logic                learn_hit;
    logic                idx_ok;
    logic [6:0]          idx7;
    logic                hit;
    logic                scan_rd;
    logic                scan_last;
    logic                handover;

    t_tbl_ctl            tbl_ctl;
    logic [TBL_AW-1:0]   tbl_addr;
    t_binding            tbl_rd;
    t_ring_ctl           ring_ctl;
    t_ring_sts           ring_sts;
    logic [ACT_W-1:0]    ring_pop_action;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign op      = t_op'(i_op);
    assign is_chan = (i_status_byte >= CHANNEL_LOW) && (i_status_byte < CHANNEL_END);

    // channel message captured into the armed slot
    assign learn_hit = (op == OP_MIDI) && is_chan && r_armed;

    // negative indices have the sign bit set; the rest compare unsigned
    assign idx_ok = !i_action_index[3] && !i_slot_index[3]
                 && ($unsigned(i_action_index) < 4'(NUM_ACTIONS))
                 && ($unsigned(i_slot_index) < 4'(SLOTS_PER_ACTION));
    assign idx7   = 7'(i_action_index[2:0]) * 7'(SLOTS_PER_ACTION) + 7'(i_slot_index[2:0]);

    // compare the entry read last cycle
    assign hit = r_cmp_vld && tbl_rd.valid
              && (tbl_rd.status == r_status) && (tbl_rd.data == r_data);

    assign scan_rd   = (r_state == S_SCAN) && !r_issue_done && !hit;
    assign scan_last = (r_scan_act == ACT_W'(NUM_ACTIONS - 1))
                    && (r_scan_slot == SLOT_W'(SLOTS_PER_ACTION - 1));

    // result moves to the output register once that register is free
    assign handover = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        tbl_ctl  = '0;
        tbl_addr = r_scan_addr;
        ring_ctl = '0;
        if (accept) begin
            case (op)
                OP_MIDI: begin
                    if (is_chan && r_armed) begin
                        tbl_ctl.wr = 1'b1;
                        tbl_addr   = r_learn_addr;
                    end
                end
                OP_CLEAR: begin
                    if (idx_ok) begin
                        tbl_ctl.clr = 1'b1;
                        tbl_addr    = TBL_AW'(idx7);
                    end
                end
                OP_POP: begin
                    ring_ctl.pop = !ring_sts.empty;
                end
                default: begin
                end
            endcase
        end
        if (r_state == S_SCAN) begin
            tbl_ctl.rd    = scan_rd;
            ring_ctl.push = hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_armed      <= 1'b0;
            r_learn_addr <= '0;
            r_out_valid  <= 1'b0;
            r_issue_done <= 1'b0;
            r_cmp_vld    <= 1'b0;
        end else begin
            if (handover) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status       <= i_status_byte;
                        r_data         <= i_first_data;
                        r_res_consumed <= learn_hit;
                        r_res_learned  <= learn_hit;
                        r_res_pvalid   <= 1'b0;
                        r_res_paction  <= '0;
                        case (op)
                            OP_MIDI: begin
                                if (is_chan && r_armed) begin
                                    r_armed      <= 1'b0;
                                    r_learn_addr <= '0;
                                    r_state      <= S_DONE;
                                end else if (is_chan) begin
                                    r_scan_act   <= '0;
                                    r_scan_slot  <= '0;
                                    r_scan_addr  <= '0;
                                    r_issue_done <= 1'b0;
                                    r_cmp_vld    <= 1'b0;
                                    r_state      <= S_SCAN;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            OP_LEARN: begin
                                r_armed      <= idx_ok;
                                r_learn_addr <= idx_ok ? TBL_AW'(idx7) : '0;
                                r_state      <= S_DONE;
                            end
                            OP_POP: begin
                                if (!ring_sts.empty) begin
                                    r_state <= S_POP;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_rd) begin
                        if (r_scan_slot == SLOT_W'(SLOTS_PER_ACTION - 1)) begin
                            r_scan_slot <= '0;
                            r_scan_act  <= r_scan_act + ACT_W'(1);
                        end else begin
                            r_scan_slot <= r_scan_slot + SLOT_W'(1);
                        end
                        r_scan_addr  <= r_scan_addr + TBL_AW'(1);
                        r_issue_done <= scan_last;
                    end
                    r_cmp_vld  <= scan_rd;
                    r_cmp_act  <= r_scan_act;
                    r_cmp_last <= scan_last;
                    if (hit) begin
                        r_res_consumed <= 1'b1;
                        r_state        <= S_DONE;
                    end else if (r_cmp_vld && r_cmp_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_POP: begin
                    r_res_pvalid  <= 1'b1;
                    r_res_paction <= 3'(ring_pop_action);
                    r_state       <= S_DONE;
                end
                S_DONE: begin
                    if (handover) begin
                        r_out_consumed <= r_res_consumed;
                        r_out_learned  <= r_res_learned;
                        r_out_pvalid   <= r_res_pvalid;
                        r_out_paction  <= r_res_paction;
                        r_out_armed    <= r_armed;
                        r_cmp_vld      <= 1'b0;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_consumed      = r_out_consumed;
    assign o_learned       = r_out_learned;
    assign o_popped_valid  = r_out_pvalid;
    assign o_popped_action = r_out_paction;
    assign o_learn_armed   = r_out_armed;

    mlbd_table #(
        .TBL_DEPTH (TBL_DEPTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (tbl_ctl),
        .i_addr      (tbl_addr),
        .i_wr_status (i_status_byte),
        .i_wr_data   (i_first_data),
        .o_rd        (tbl_rd)
    );

    mlbd_ring #(
        .RING_DEPTH (RING_DEPTH),
        .ACT_W      (ACT_W)
    ) u_ring (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ring_ctl),
        .i_push_action (r_cmp_act),
        .o_pop_action  (ring_pop_action),
        .o_sts         (ring_sts)
    );

    // no table update while a scan is reading it
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (!tbl_ctl.wr && !tbl_ctl.clr))
        else $error("table written during scan");

    // pops only from a non-empty ring
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_ctl.pop |-> !ring_sts.empty)
        else $error("pop from empty ring");

    // a push always leaves something queued
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_ctl.push |=> !ring_sts.empty)
        else $error("ring empty after push");

    // a waiting result is never overwritten
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_stall) |=> (r_state == S_DONE))
        else $error("result register overwritten");

    // learned implies consumed
    a_learned_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_learned || o_consumed))
        else $error("learned without consumed");

endmodule

`default_nettype wire
